### sv/ppsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppsa_pkg
// Shared widths, constants, types and helpers of the particle pool block.
// ----------------------------------------------------------------------------
package ppsa_pkg;

    localparam int POOL_SIZE = 64;
    localparam int SLOT_W    = $clog2(POOL_SIZE);
    localparam int SLOT_OUT_W = 6;

    localparam int SPEED_W = 24;
    localparam int LIFE_W  = 24;
    localparam int SPAWN_W = 7;
    localparam int SEED_W  = 16;
    localparam int DELTA_W = 16;
    localparam int POS_W   = 32;
    localparam int DIR_W   = 16;
    localparam int ALPHA_W = 16;
    localparam int SHADE_W = 8;

    localparam int FADE_SH = 15;
    localparam int FADE_W  = DELTA_W + FADE_SH;
    localparam int K_W     = SPEED_W + DELTA_W;
    localparam int PROD_W  = DIR_W + K_W + 1;
    localparam int MOVE_SH = 22;
    localparam int STEP_W  = PROD_W - MOVE_SH;

    localparam logic [SPEED_W-1:0] SPEED_RST = 24'd256;
    localparam logic [LIFE_W-1:0]  LIFE_RST  = 24'd65536;
    localparam logic [SPAWN_W-1:0] SPAWN_RST = 7'd1;
    localparam logic [SEED_W-1:0]  SEED_RST  = 16'd44257;

    localparam logic [SEED_W-1:0]        LFSR_MASK  = 16'hB400;
    localparam logic signed [ALPHA_W-1:0] ALPHA_ONE = 16'sd16384;
    localparam logic [SHADE_W-1:0]       SHADE_BASE = 8'd50;
    localparam int                       SHADE_MOD  = 100;
    // reciprocal of 100, exact for every 16-bit value
    localparam int                       RECIP_W    = 17;
    localparam logic [RECIP_W-1:0]       RECIP_MUL  = 17'd83887;
    localparam int                       RECIP_SH   = 23;
    localparam int                       QPROD_W    = SEED_W + RECIP_W;
    localparam int                       Q_W        = 10;

    typedef enum logic [1:0] {
        REG_SPEED = 2'd0,
        REG_LIFE  = 2'd1,
        REG_SPAWN = 2'd2,
        REG_SEED  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [LIFE_W-1:0]         life;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pos_z;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic signed [DIR_W-1:0]   dir_z;
        logic [SPEED_W-1:0]        speed;
        logic signed [ALPHA_W-1:0] alpha;
        logic [SHADE_W-1:0]        shade;
    } t_entry;

    typedef struct packed {
        logic load;
        logic srch_init;
        logic srch_step;
        logic spawn_wr;
        logic age_rd;
        logic mul1;
        logic mul2;
        logic wb;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic spawn_done;
        logic srch_stop;
        logic out_free;
        logic age_last;
    } t_sts;

    function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] v);
        logic [SEED_W-1:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ LFSR_MASK;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

### sv/ppsa_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppsa_in_if
// Update item channel: elapsed time, emitter position and heading.
// ----------------------------------------------------------------------------
interface ppsa_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [ppsa_pkg::DELTA_W-1:0]           delta;
    logic signed [ppsa_pkg::POS_W-1:0]      spawn_x;
    logic signed [ppsa_pkg::POS_W-1:0]      spawn_y;
    logic signed [ppsa_pkg::DIR_W-1:0]      heading_x;
    logic signed [ppsa_pkg::DIR_W-1:0]      heading_y;
    logic signed [ppsa_pkg::DIR_W-1:0]      heading_z;

    modport source (output valid, delta, spawn_x, spawn_y, heading_x, heading_y,
                    heading_z, input ready);
    modport sink (input valid, delta, spawn_x, spawn_y, heading_x, heading_y,
                  heading_z, output ready);
endinterface
`default_nettype wire

### sv/ppsa_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppsa_out_if
// Particle result channel: one transfer per pool slot.
// ----------------------------------------------------------------------------
interface ppsa_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [ppsa_pkg::SLOT_OUT_W-1:0]        slot;
    logic                                   alive;
    logic signed [ppsa_pkg::POS_W-1:0]      out_x;
    logic signed [ppsa_pkg::POS_W-1:0]      out_y;
    logic signed [ppsa_pkg::POS_W-1:0]      out_z;
    logic [ppsa_pkg::SHADE_W-1:0]           shade;
    logic signed [ppsa_pkg::ALPHA_W-1:0]    alpha;
    logic                                   last;

    modport source (output valid, slot, alive, out_x, out_y, out_z, shade, alpha,
                    last, input ready);
    modport sink (input valid, slot, alive, out_x, out_y, out_z, shade, alpha,
                  last, output ready);
endinterface
`default_nettype wire

### sv/ppsa_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppsa_div
// Restoring divider, one quotient bit per cycle, for the alpha fade step.
// ----------------------------------------------------------------------------
module ppsa_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [ppsa_pkg::FADE_W-1:0]    i_dividend,
    input  wire logic [ppsa_pkg::LIFE_W-1:0]    i_divisor,
    output logic                                o_busy,
    output logic [ppsa_pkg::FADE_W-1:0]         o_quot
);
    localparam int CNT_W = $clog2(ppsa_pkg::FADE_W);

    logic                           r_busy;
    logic [CNT_W-1:0]               r_cnt;
    logic [ppsa_pkg::LIFE_W-1:0]    r_rem;
    logic [ppsa_pkg::LIFE_W-1:0]    r_dvs;
    logic [ppsa_pkg::FADE_W-1:0]    r_quo;
    logic [ppsa_pkg::LIFE_W:0]      w_trial;
    logic                           w_fit;

    assign w_trial = {r_rem, r_quo[ppsa_pkg::FADE_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(ppsa_pkg::FADE_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? ppsa_pkg::LIFE_W'(w_trial - {1'b0, r_dvs})
                           : w_trial[ppsa_pkg::LIFE_W-1:0];
            r_quo <= {r_quo[ppsa_pkg::FADE_W-2:0], w_fit};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;
endmodule
`default_nettype wire

### sv/ppsa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppsa_ctrl
// Sequencer: fade division, spawn search and load, then per-slot ageing.
// ----------------------------------------------------------------------------
module ppsa_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire ppsa_pkg::t_sts i_sts,
    output ppsa_pkg::t_cmd      o_cmd
);
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DIV   = 9'b000000010,
        ST_SCHK  = 9'b000000100,
        ST_SRCH  = 9'b000001000,
        ST_SPAWN = 9'b000010000,
        ST_RD    = 9'b000100000,
        ST_M1    = 9'b001000000,
        ST_M2    = 9'b010000000,
        ST_WB    = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = ST_SCHK;
                end
            end
            ST_SCHK: begin
                if (i_sts.spawn_done) begin
                    n_state = ST_RD;
                end else begin
                    o_cmd.srch_init = 1'b1;
                    n_state         = ST_SRCH;
                end
            end
            ST_SRCH: begin
                if (i_sts.srch_stop) begin
                    n_state = ST_SPAWN;
                end else begin
                    o_cmd.srch_step = 1'b1;
                end
            end
            ST_SPAWN: begin
                o_cmd.spawn_wr = 1'b1;
                n_state        = ST_SCHK;
            end
            ST_RD: begin
                o_cmd.age_rd = 1'b1;
                n_state      = ST_M1;
            end
            ST_M1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_M2;
            end
            ST_M2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_WB;
            end
            ST_WB: begin
                if (i_sts.out_free) begin
                    o_cmd.wb = 1'b1;
                    n_state  = i_sts.age_last ? ST_IDLE : ST_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
endmodule
`default_nettype wire

### sv/ppsa_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppsa_dp
// Particle store, free slot search, shade generator and ageing arithmetic.
// ----------------------------------------------------------------------------
module ppsa_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire ppsa_pkg::t_cmd                     i_cmd,
    output ppsa_pkg::t_sts                          o_sts,
    input  wire logic [ppsa_pkg::SPEED_W-1:0]       i_speed,
    input  wire logic [ppsa_pkg::LIFE_W-1:0]        i_life,
    input  wire logic [ppsa_pkg::SPAWN_W-1:0]       i_spawn_amt,
    input  wire logic                               i_seed_wr,
    input  wire logic [ppsa_pkg::SEED_W-1:0]        i_seed,
    input  wire logic [ppsa_pkg::DELTA_W-1:0]       i_delta,
    input  wire logic signed [ppsa_pkg::POS_W-1:0]  i_spawn_x,
    input  wire logic signed [ppsa_pkg::POS_W-1:0]  i_spawn_y,
    input  wire logic signed [ppsa_pkg::DIR_W-1:0]  i_heading_x,
    input  wire logic signed [ppsa_pkg::DIR_W-1:0]  i_heading_y,
    input  wire logic signed [ppsa_pkg::DIR_W-1:0]  i_heading_z,
    input  wire logic                               i_out_ready,
    output logic                                    o_out_valid,
    output logic [ppsa_pkg::SLOT_OUT_W-1:0]         o_slot,
    output logic                                    o_alive,
    output logic signed [ppsa_pkg::POS_W-1:0]       o_out_x,
    output logic signed [ppsa_pkg::POS_W-1:0]       o_out_y,
    output logic signed [ppsa_pkg::POS_W-1:0]       o_out_z,
    output logic [ppsa_pkg::SHADE_W-1:0]            o_shade,
    output logic signed [ppsa_pkg::ALPHA_W-1:0]     o_alpha,
    output logic                                    o_last
);
    localparam logic [ppsa_pkg::SLOT_W-1:0] LAST_SLOT =
        ppsa_pkg::SLOT_W'(ppsa_pkg::POOL_SIZE - 1);

    // item registers
    logic [ppsa_pkg::DELTA_W-1:0]           r_delta;
    logic signed [ppsa_pkg::POS_W-1:0]      r_px;
    logic signed [ppsa_pkg::POS_W-1:0]      r_py;
    logic signed [ppsa_pkg::DIR_W-1:0]      r_hx;
    logic signed [ppsa_pkg::DIR_W-1:0]      r_hy;
    logic signed [ppsa_pkg::DIR_W-1:0]      r_hz;

    // fade divider
    logic                                   w_div_busy;
    logic [ppsa_pkg::FADE_W-1:0]            w_fade;
    logic [ppsa_pkg::LIFE_W-1:0]            w_divisor;

    // spawn and search
    logic [ppsa_pkg::SPAWN_W-1:0]           r_spn;
    logic [ppsa_pkg::SLOT_W-1:0]            r_start;
    logic [ppsa_pkg::SLOT_W-1:0]            r_sidx;
    logic [ppsa_pkg::SLOT_W-1:0]            r_scnt;
    logic [ppsa_pkg::SLOT_W-1:0]            w_spawn_slot;
    logic [ppsa_pkg::POOL_SIZE-1:0]         r_live;
    logic [ppsa_pkg::POOL_SIZE-1:0]         r_vld;

    // shade generator
    logic [ppsa_pkg::SEED_W-1:0]            r_lfsr;
    logic [ppsa_pkg::SEED_W-1:0]            w_lfsr_nx;
    logic [ppsa_pkg::QPROD_W-1:0]           w_qprod;
    logic [ppsa_pkg::Q_W-1:0]               r_q;
    logic [ppsa_pkg::SEED_W-1:0]            w_rem;
    logic [ppsa_pkg::SHADE_W-1:0]           w_shade;

    // store and ageing
    ppsa_pkg::t_entry                       r_mem [ppsa_pkg::POOL_SIZE];
    ppsa_pkg::t_entry                       r_rd;
    logic                                   r_rd_vld;
    ppsa_pkg::t_entry                       w_ent;
    ppsa_pkg::t_entry                       w_spawn_ent;
    ppsa_pkg::t_entry                       w_age_ent;
    ppsa_pkg::t_entry                       w_wdata;
    logic [ppsa_pkg::SLOT_W-1:0]            w_waddr;
    logic                                   w_we;
    logic [ppsa_pkg::SLOT_W-1:0]            r_aidx;
    logic [ppsa_pkg::LIFE_W-1:0]            r_life;
    logic [ppsa_pkg::K_W-1:0]               r_k;
    logic signed [ppsa_pkg::PROD_W-1:0]     r_prx;
    logic signed [ppsa_pkg::PROD_W-1:0]     r_pry;
    logic signed [ppsa_pkg::PROD_W-1:0]     r_prz;
    logic                                   w_alive;
    logic signed [ppsa_pkg::ALPHA_W:0]      w_alpha_sub;
    logic signed [ppsa_pkg::POS_W:0]        w_alpha_diff;

    // output register
    logic                                   r_ovld;
    logic [ppsa_pkg::SLOT_OUT_W-1:0]        r_o_slot;
    logic                                   r_o_alive;
    logic signed [ppsa_pkg::POS_W-1:0]      r_o_x;
    logic signed [ppsa_pkg::POS_W-1:0]      r_o_y;
    logic signed [ppsa_pkg::POS_W-1:0]      r_o_z;
    logic [ppsa_pkg::SHADE_W-1:0]           r_o_shade;
    logic signed [ppsa_pkg::ALPHA_W-1:0]    r_o_alpha;
    logic                                   r_o_last;

    function automatic logic signed [ppsa_pkg::POS_W-1:0] move_sat(
        input logic signed [ppsa_pkg::POS_W-1:0]  pos,
        input logic signed [ppsa_pkg::PROD_W-1:0] prod
    );
        logic signed [ppsa_pkg::PROD_W-1:0] sh;
        logic [ppsa_pkg::STEP_W-1:0]        step;
        logic signed [ppsa_pkg::STEP_W:0]   sum;
        // arithmetic shift rounds towards minus infinity
        sh   = prod >>> ppsa_pkg::MOVE_SH;
        step = sh[ppsa_pkg::STEP_W-1:0];
        sum  = $signed({{(ppsa_pkg::STEP_W + 1 - ppsa_pkg::POS_W){pos[ppsa_pkg::POS_W-1]}}, pos})
             + $signed({step[ppsa_pkg::STEP_W-1], step});
        if (sum > $signed({{(ppsa_pkg::STEP_W + 1 - ppsa_pkg::POS_W){1'b0}},
                           1'b0, {(ppsa_pkg::POS_W-1){1'b1}}})) begin
            return {1'b0, {(ppsa_pkg::POS_W-1){1'b1}}};
        end else if (sum < $signed({{(ppsa_pkg::STEP_W + 1 - ppsa_pkg::POS_W){1'b1}},
                                    1'b1, {(ppsa_pkg::POS_W-1){1'b0}}})) begin
            return {1'b1, {(ppsa_pkg::POS_W-1){1'b0}}};
        end
        return sum[ppsa_pkg::POS_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_delta <= i_delta;
            r_px    <= i_spawn_x;
            r_py    <= i_spawn_y;
            r_hx    <= i_heading_x;
            r_hy    <= i_heading_y;
            r_hz    <= i_heading_z;
        end
    end

    // a zero life register fades as if it were one
    assign w_divisor = (i_life == '0) ? ppsa_pkg::LIFE_W'(1) : i_life;

    ppsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.load),
        .i_dividend ({i_delta, {ppsa_pkg::FADE_SH{1'b0}}}),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quot     (w_fade)
    );

    // circular free slot search, slot 0 when the pool is full
    assign w_spawn_slot = r_live[r_sidx] ? '0 : r_sidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spn   <= '0;
            r_start <= '0;
            r_sidx  <= '0;
            r_scnt  <= '0;
            r_aidx  <= '0;
            r_lfsr  <= ppsa_pkg::SEED_RST;
        end else begin
            if (i_cmd.load) begin
                r_spn  <= i_spawn_amt;
                r_aidx <= '0;
            end
            if (i_cmd.srch_init) begin
                r_sidx <= r_start;
                r_scnt <= '0;
            end
            if (i_cmd.srch_step) begin
                r_sidx <= (r_sidx == LAST_SLOT) ? '0 : r_sidx + 1'b1;
                r_scnt <= r_scnt + 1'b1;
            end
            if (i_cmd.spawn_wr) begin
                r_spn   <= r_spn - 1'b1;
                r_start <= w_spawn_slot;
            end
            if (i_seed_wr) begin
                r_lfsr <= (i_seed == '0) ? ppsa_pkg::SEED_W'(1) : i_seed;
            end else if (i_cmd.spawn_wr) begin
                r_lfsr <= w_lfsr_nx;
            end
            if (i_cmd.wb) begin
                r_aidx <= (r_aidx == LAST_SLOT) ? '0 : r_aidx + 1'b1;
            end
        end
    end

    // shade = 50 + next lfsr mod 100, quotient by reciprocal registered ahead of use
    assign w_lfsr_nx = ppsa_pkg::lfsr_step(r_lfsr);
    assign w_qprod   = ppsa_pkg::QPROD_W'(w_lfsr_nx) * ppsa_pkg::QPROD_W'(ppsa_pkg::RECIP_MUL);
    assign w_rem     = w_lfsr_nx - ppsa_pkg::SEED_W'(r_q * ppsa_pkg::SHADE_MOD);
    assign w_shade   = ppsa_pkg::SHADE_BASE + w_rem[ppsa_pkg::SHADE_W-1:0];

    always_ff @(posedge i_clk) begin
        r_q <= ppsa_pkg::Q_W'(w_qprod >> ppsa_pkg::RECIP_SH);
    end

    always_comb begin
        w_spawn_ent       = '0;
        w_spawn_ent.life  = i_life;
        w_spawn_ent.pos_x = r_px;
        w_spawn_ent.pos_y = r_py;
        w_spawn_ent.dir_x = r_hx;
        w_spawn_ent.dir_y = r_hy;
        w_spawn_ent.dir_z = r_hz;
        w_spawn_ent.speed = i_speed;
        w_spawn_ent.alpha = ppsa_pkg::ALPHA_ONE;
        w_spawn_ent.shade = w_shade;
    end

    // slots never written read as zero
    assign w_ent = r_rd_vld ? r_rd : '0;

    assign w_alive      = (r_life != '0);
    assign w_alpha_diff = (ppsa_pkg::POS_W + 1)'(w_ent.alpha) - $signed({2'b00, w_fade});

    always_comb begin
        w_alpha_sub = '0;
        if (w_alpha_diff < -$signed((ppsa_pkg::POS_W + 1)'(32768))) begin
            w_alpha_sub = {1'b1, 1'b1, {(ppsa_pkg::ALPHA_W-1){1'b0}}};
        end else begin
            w_alpha_sub = w_alpha_diff[ppsa_pkg::ALPHA_W:0];
        end
    end

    always_comb begin
        w_age_ent      = w_ent;
        w_age_ent.life = r_life;
        if (w_alive) begin
            w_age_ent.pos_x = move_sat(w_ent.pos_x, r_prx);
            w_age_ent.pos_y = move_sat(w_ent.pos_y, r_pry);
            w_age_ent.pos_z = move_sat(w_ent.pos_z, r_prz);
            w_age_ent.alpha = w_alpha_sub[ppsa_pkg::ALPHA_W-1:0];
        end
    end

    assign w_we    = i_cmd.spawn_wr || i_cmd.wb;
    assign w_waddr = i_cmd.spawn_wr ? w_spawn_slot : r_aidx;
    assign w_wdata = i_cmd.spawn_wr ? w_spawn_ent : w_age_ent;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.age_rd) begin
            r_rd     <= r_mem[r_aidx];
            r_rd_vld <= r_vld[r_aidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_live <= '0;
        end else if (w_we) begin
            r_vld[w_waddr]  <= 1'b1;
            r_live[w_waddr] <= i_cmd.spawn_wr ? (i_life != '0) : w_alive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_life <= (w_ent.life > ppsa_pkg::LIFE_W'(r_delta))
                    ? w_ent.life - ppsa_pkg::LIFE_W'(r_delta) : '0;
            r_k    <= ppsa_pkg::K_W'(w_ent.speed) * ppsa_pkg::K_W'(r_delta);
        end
        if (i_cmd.mul2) begin
            r_prx <= ppsa_pkg::PROD_W'(w_ent.dir_x) * $signed({1'b0, r_k});
            r_pry <= ppsa_pkg::PROD_W'(w_ent.dir_y) * $signed({1'b0, r_k});
            r_prz <= ppsa_pkg::PROD_W'(w_ent.dir_z) * $signed({1'b0, r_k});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.wb) begin
            r_ovld <= 1'b1;
        end else if (i_out_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            r_o_slot  <= ppsa_pkg::SLOT_OUT_W'(r_aidx);
            r_o_alive <= w_alive;
            r_o_x     <= w_age_ent.pos_x;
            r_o_y     <= w_age_ent.pos_y;
            r_o_z     <= w_age_ent.pos_z;
            r_o_shade <= w_age_ent.shade;
            r_o_alpha <= w_age_ent.alpha;
            r_o_last  <= (r_aidx == LAST_SLOT);
        end
    end

    assign o_sts.div_busy   = w_div_busy;
    assign o_sts.spawn_done = (r_spn == '0);
    assign o_sts.srch_stop  = !r_live[r_sidx] || (r_scnt == LAST_SLOT);
    assign o_sts.out_free   = !r_ovld || i_out_ready;
    assign o_sts.age_last   = (r_aidx == LAST_SLOT);

    assign o_out_valid = r_ovld;
    assign o_slot      = r_o_slot;
    assign o_alive     = r_o_alive;
    assign o_out_x     = r_o_x;
    assign o_out_y     = r_o_y;
    assign o_out_z     = r_o_z;
    assign o_shade     = r_o_shade;
    assign o_alpha     = r_o_alpha;
    assign o_last      = r_o_last;

    a_wb_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wb |=> r_ovld)
        else $error("write-back did not fill the output register");

    a_wb_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wb |-> (!r_ovld || i_out_ready))
        else $error("write-back would overwrite a pending transfer");

    a_spawn_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.spawn_wr |=> (r_live[r_start] == ($past(i_life) != '0)))
        else $error("spawned slot live flag wrong");

    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_o_last) |-> (r_o_slot == ppsa_pkg::SLOT_OUT_W'(LAST_SLOT)))
        else $error("last flag on a slot other than the final one");
endmodule
`default_nettype wire

### sv/particle_pool_spawn_and_age.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// particle_pool_spawn_and_age
// 64-slot particle pool: spawns, ages and emits every slot per update item.
// ----------------------------------------------------------------------------
// One update item is taken at a time; the input is ready only between
// updates. An update runs the alpha fade division, then per spawned
// particle a check, a one slot a cycle free slot scan and a store write,
// then per slot a read, the ageing multiplies and a write-back through
// the particle store, the write-back held while the result channel
// stalls. The 64 results of an update leave through an output register
// in slot order, last set on slot 63. There is no clearing pass after
// reset: per-slot valid bits make unused slots read as zero.
module particle_pool_spawn_and_age (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    ppsa_in_if.sink             i_in,
    ppsa_out_if.source          o_out,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    logic [ppsa_pkg::SPEED_W-1:0]   r_speed;
    logic [ppsa_pkg::LIFE_W-1:0]    r_life;
    logic [ppsa_pkg::SPAWN_W-1:0]   r_spawn;
    logic [ppsa_pkg::SEED_W-1:0]    r_seed;
    logic                           w_wr;
    logic                           w_seed_wr;
    ppsa_pkg::t_reg_idx             w_idx;
    ppsa_pkg::t_cmd                 w_cmd;
    ppsa_pkg::t_sts                 w_sts;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = ppsa_pkg::t_reg_idx'(paddr[3:2]);

    always_comb begin
        w_seed_wr = 1'b0;
        unique case (w_idx)
            ppsa_pkg::REG_SEED: w_seed_wr = w_wr;
            default:            w_seed_wr = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= ppsa_pkg::SPEED_RST;
            r_life  <= ppsa_pkg::LIFE_RST;
            r_spawn <= ppsa_pkg::SPAWN_RST;
            r_seed  <= ppsa_pkg::SEED_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                ppsa_pkg::REG_SPEED: r_speed <= pwdata[ppsa_pkg::SPEED_W-1:0];
                ppsa_pkg::REG_LIFE:  r_life  <= pwdata[ppsa_pkg::LIFE_W-1:0];
                ppsa_pkg::REG_SPAWN: r_spawn <= pwdata[ppsa_pkg::SPAWN_W-1:0];
                ppsa_pkg::REG_SEED:  r_seed  <= pwdata[ppsa_pkg::SEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            ppsa_pkg::REG_SPEED: prdata = 32'(r_speed);
            ppsa_pkg::REG_LIFE:  prdata = 32'(r_life);
            ppsa_pkg::REG_SPAWN: prdata = 32'(r_spawn);
            ppsa_pkg::REG_SEED:  prdata = 32'(r_seed);
            default:             prdata = '0;
        endcase
    end

    ppsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ppsa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_speed     (r_speed),
        .i_life      (r_life),
        .i_spawn_amt (r_spawn),
        .i_seed_wr   (w_seed_wr),
        .i_seed      (pwdata[ppsa_pkg::SEED_W-1:0]),
        .i_delta     (i_in.delta),
        .i_spawn_x   (i_in.spawn_x),
        .i_spawn_y   (i_in.spawn_y),
        .i_heading_x (i_in.heading_x),
        .i_heading_y (i_in.heading_y),
        .i_heading_z (i_in.heading_z),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_slot      (o_out.slot),
        .o_alive     (o_out.alive),
        .o_out_x     (o_out.out_x),
        .o_out_y     (o_out.out_y),
        .o_out_z     (o_out.out_z),
        .o_shade     (o_out.shade),
        .o_alpha     (o_out.alpha),
        .o_last      (o_out.last)
    );
endmodule
`default_nettype wire

### tb/tb_particle_pool_spawn_and_age.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_particle_pool_spawn_and_age
// Checks the particle pool against a cycle-free predictor: random update
// items with burst gaps, result stalls, one long hold-off and register
// phases that cover the extremes of speed, life, spawn amount and seed.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [ppsa_pkg::DELTA_W-1:0]        delta;
    logic signed [ppsa_pkg::POS_W-1:0]   sx;
    logic signed [ppsa_pkg::POS_W-1:0]   sy;
    logic signed [ppsa_pkg::DIR_W-1:0]   hx;
    logic signed [ppsa_pkg::DIR_W-1:0]   hy;
    logic signed [ppsa_pkg::DIR_W-1:0]   hz;
} t_update;

typedef struct packed {
    logic [ppsa_pkg::SLOT_OUT_W-1:0]     slot;
    logic                                alive;
    logic signed [ppsa_pkg::POS_W-1:0]   x;
    logic signed [ppsa_pkg::POS_W-1:0]   y;
    logic signed [ppsa_pkg::POS_W-1:0]   z;
    logic [ppsa_pkg::SHADE_W-1:0]        shade;
    logic signed [ppsa_pkg::ALPHA_W-1:0] alpha;
    logic                                last;
} t_particle;

class pool_scoreboard;
    logic [ppsa_pkg::LIFE_W-1:0]         life_q [ppsa_pkg::POOL_SIZE];
    logic signed [ppsa_pkg::POS_W-1:0]   px [ppsa_pkg::POOL_SIZE];
    logic signed [ppsa_pkg::POS_W-1:0]   py [ppsa_pkg::POOL_SIZE];
    logic signed [ppsa_pkg::POS_W-1:0]   pz [ppsa_pkg::POOL_SIZE];
    logic signed [ppsa_pkg::DIR_W-1:0]   dx [ppsa_pkg::POOL_SIZE];
    logic signed [ppsa_pkg::DIR_W-1:0]   dy [ppsa_pkg::POOL_SIZE];
    logic signed [ppsa_pkg::DIR_W-1:0]   dz [ppsa_pkg::POOL_SIZE];
    logic [ppsa_pkg::SPEED_W-1:0]        spd [ppsa_pkg::POOL_SIZE];
    logic signed [ppsa_pkg::ALPHA_W-1:0] alp [ppsa_pkg::POOL_SIZE];
    logic [ppsa_pkg::SHADE_W-1:0]        shd [ppsa_pkg::POOL_SIZE];
    int                                  next_search;
    logic [ppsa_pkg::SEED_W-1:0]         noise;
    logic [ppsa_pkg::SPEED_W-1:0]        cfg_speed;
    logic [ppsa_pkg::LIFE_W-1:0]         cfg_life;
    logic [ppsa_pkg::SPAWN_W-1:0]        cfg_spawn;
    t_particle                           pending [$];
    int                                  mismatches;
    int                                  checked;

    function new();
        for (int i = 0; i < ppsa_pkg::POOL_SIZE; i++) begin
            life_q[i] = '0; px[i] = '0; py[i] = '0; pz[i] = '0;
            dx[i] = '0; dy[i] = '0; dz[i] = '0; spd[i] = '0; alp[i] = '0; shd[i] = '0;
        end
        next_search = 0;
        cfg_speed = ppsa_pkg::SPEED_RST;
        cfg_life = ppsa_pkg::LIFE_RST;
        cfg_spawn = ppsa_pkg::SPAWN_RST;
        noise = ppsa_pkg::SEED_RST;
        mismatches = 0;
        checked = 0;
    endfunction

    function void write_reg(ppsa_pkg::t_reg_idx idx, logic [31:0] v);
        case (idx)
            ppsa_pkg::REG_SPEED: cfg_speed = v[ppsa_pkg::SPEED_W-1:0];
            ppsa_pkg::REG_LIFE:  cfg_life = v[ppsa_pkg::LIFE_W-1:0];
            ppsa_pkg::REG_SPAWN: cfg_spawn = v[ppsa_pkg::SPAWN_W-1:0];
            ppsa_pkg::REG_SEED: begin
                noise = (v[ppsa_pkg::SEED_W-1:0] == 0) ? 16'd1 : v[ppsa_pkg::SEED_W-1:0];
            end
            default: ;
        endcase
    endfunction

    function longint floor_move(longint v);
        if (v >= 0) return v >>> 22;
        return -((-v + 64'h3FFFFF) >>> 22);
    endfunction

    function logic signed [ppsa_pkg::POS_W-1:0] clamp(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function int pick_slot();
        for (int i = next_search; i < ppsa_pkg::POOL_SIZE; i++) if (life_q[i] == 0) return i;
        for (int i = 0; i < next_search; i++) if (life_q[i] == 0) return i;
        return 0;
    endfunction

    // one update: spawn, then age and emit every slot
    function void note_update(t_update u);
        longint    fade;
        longint    k;
        longint    a;
        int        s;
        t_particle p;
        fade = (longint'(u.delta) << 15) / ((cfg_life == 0) ? 1 : longint'(cfg_life));
        for (int n = 0; n < cfg_spawn; n++) begin
            s = pick_slot();
            next_search = s;
            life_q[s] = cfg_life;
            px[s] = u.sx; py[s] = u.sy; pz[s] = '0;
            dx[s] = u.hx; dy[s] = u.hy; dz[s] = u.hz;
            spd[s] = cfg_speed;
            alp[s] = ppsa_pkg::ALPHA_ONE;
            noise = (noise >> 1) ^ (noise[0] ? 16'hB400 : 16'h0);
            shd[s] = 8'(50 + noise % 100);
        end
        for (int i = 0; i < ppsa_pkg::POOL_SIZE; i++) begin
            life_q[i] = (life_q[i] > u.delta) ? life_q[i] - u.delta : '0;
            if (life_q[i] != 0) begin
                k = longint'(spd[i]) * longint'(u.delta);
                px[i] = clamp(longint'(px[i]) + floor_move(longint'(dx[i]) * k));
                py[i] = clamp(longint'(py[i]) + floor_move(longint'(dy[i]) * k));
                pz[i] = clamp(longint'(pz[i]) + floor_move(longint'(dz[i]) * k));
                a = longint'(alp[i]) - fade;
                alp[i] = (a < -32768) ? -16'sd32768 : a[15:0];
            end
            p.slot = ppsa_pkg::SLOT_OUT_W'(i); p.alive = (life_q[i] != 0);
            p.x = px[i]; p.y = py[i]; p.z = pz[i];
            p.shade = shd[i]; p.alpha = alp[i]; p.last = (i == ppsa_pkg::POOL_SIZE - 1);
            pending.insert(pending.size(), p);
        end
    endfunction

    function void check_particle(t_particle got);
        t_particle want;
        checked++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected particle transfer slot %0d", got.slot);
            return;
        end
        want = pending.pop_front();
        if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: want slot %0d alive %0b x %h y %h z %h sh %0d a %h l %0b\n%s%0d alive %0b x %h y %h z %h sh %0d a %h l %0b",
                    want.slot, want.alive, want.x, want.y, want.z, want.shade,
                    want.alpha, want.last, "          got  slot ", got.slot,
                    got.alive, got.x, got.y, got.z, got.shade, got.alpha, got.last);
        end
    endfunction
endclass

module tb_particle_pool_spawn_and_age;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [3:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    ppsa_in_if  upd_if ();
    ppsa_out_if part_if ();

    pool_scoreboard sb;
    int  idle_cycles = 0;
    int  hold_off = 0;
    int  updates_sent = 0;

    particle_pool_spawn_and_age i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (upd_if.sink),
        .o_out   (part_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    initial begin
        upd_if.valid = 0; upd_if.delta = 0; upd_if.spawn_x = 0; upd_if.spawn_y = 0;
        upd_if.heading_x = 0; upd_if.heading_y = 0; upd_if.heading_z = 0;
        part_if.ready = 0;
    end

    // receiver: stall pattern, plus a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            part_if.ready <= 0;
        end else if (updates_sent % 40 < 12) begin
            part_if.ready <= 1;
        end else begin
            part_if.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_particle p;
        if (i_rst_n && part_if.valid && part_if.ready) begin
            p.slot = part_if.slot; p.alive = part_if.alive;
            p.x = part_if.out_x; p.y = part_if.out_y; p.z = part_if.out_z;
            p.shade = part_if.shade; p.alpha = part_if.alpha; p.last = part_if.last;
            sb.check_particle(p);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((upd_if.valid && upd_if.ready) || (part_if.valid && part_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("FAIL particle_pool_spawn_and_age");
            $finish;
        end
    end

    task automatic reg_write(ppsa_pkg::t_reg_idx idx, logic [31:0] v);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.write_reg(idx, v);
    endtask

    task automatic send_update(t_update u, bit keep_valid);
        upd_if.valid <= 1;
        upd_if.delta <= u.delta; upd_if.spawn_x <= u.sx; upd_if.spawn_y <= u.sy;
        upd_if.heading_x <= u.hx; upd_if.heading_y <= u.hy; upd_if.heading_z <= u.hz;
        do @(posedge i_clk); while (!upd_if.ready);
        sb.note_update(u);
        updates_sent++;
        @(negedge i_clk);
        if (!keep_valid) begin
            upd_if.valid <= 0;
            @(negedge i_clk);
        end
    endtask

    function automatic t_update rand_update();
        t_update u;
        u.delta = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
        u.sx = $urandom; u.sy = $urandom;
        u.hx = 16'($urandom); u.hy = 16'($urandom); u.hz = 16'($urandom);
        return u;
    endfunction

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_burst(int count);
        int left;
        left = count;
        while (left > 0) begin
            int run;
            run = $urandom_range(1, 4);
            for (int j = 0; j < run && left > 0; j++) begin
                send_update(rand_update(), (j < run - 1) && (left > 1));
                left--;
            end
            repeat ($urandom_range(0, 30)) @(negedge i_clk);
        end
    endtask

    initial begin
        t_update u;
        sb = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: reset settings, field extremes
        u = '{16'hFFFF, 32'sh7FFFFFFF, 32'sh80000000, 16'sh7FFF, 16'sh8000, 16'sh7FFF};
        send_update(u, 0);
        u = '{16'd0, 32'sh80000000, 32'sh7FFFFFFF, 16'sh8000, 16'sh7FFF, 16'sh8000};
        send_update(u, 0);
        u = '{16'd1, 32'sd0, 32'sd0, 16'sh0000, 16'shFFFF, 16'sh0001};
        send_update(u, 0);
        drain();

        // fast heavy particles saturate position, zero seed, two spawns
        reg_write(ppsa_pkg::REG_SPEED, 32'hFFFFFF);
        reg_write(ppsa_pkg::REG_LIFE, 32'hFFFFFF);
        reg_write(ppsa_pkg::REG_SPAWN, 32'd2);
        reg_write(ppsa_pkg::REG_SEED, 32'd0);
        for (int i = 0; i < 4; i++) begin
            u = '{16'hFFFF, 32'sh7FFF0000, 32'sh80010000, 16'sh7FFF, 16'sh8000, 16'sh4000};
            send_update(u, 0);
        end
        drain();

        // full pool: as many spawns as slots, then more than slots with wrap-around reuse
        reg_write(ppsa_pkg::REG_SPAWN, 32'd64);
        reg_write(ppsa_pkg::REG_SEED, 32'hFFFF);
        send_update(rand_update(), 0);
        drain();
        reg_write(ppsa_pkg::REG_SPAWN, 32'd70);
        send_update(rand_update(), 0);
        drain();

        // zero life: particles spawn dead, fade as life of one
        reg_write(ppsa_pkg::REG_LIFE, 32'd0);
        reg_write(ppsa_pkg::REG_SPAWN, 32'd3);
        reg_write(ppsa_pkg::REG_SPEED, 32'd0);
        send_update(rand_update(), 0);
        u = rand_update(); u.delta = 0;
        send_update(u, 0);
        drain();

        // short life, no spawns, then random items with long receiver hold-off
        reg_write(ppsa_pkg::REG_LIFE, 32'd1);
        reg_write(ppsa_pkg::REG_SPAWN, 32'd0);
        send_update(rand_update(), 0);
        drain();
        reg_write(ppsa_pkg::REG_LIFE, 32'd20000);
        reg_write(ppsa_pkg::REG_SPEED, 32'd4096);
        reg_write(ppsa_pkg::REG_SPAWN, 32'd5);
        reg_write(ppsa_pkg::REG_SEED, 32'd1);
        hold_off = 3000;
        send_burst(4);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            reg_write(ppsa_pkg::REG_SPEED, $urandom_range(0, 24'hFFFFFF));
            reg_write(ppsa_pkg::REG_LIFE, (ph == 2) ? 32'hFFFFFF : $urandom_range(1, 200000));
            reg_write(ppsa_pkg::REG_SPAWN, (ph == 3) ? 32'd64 : $urandom_range(0, 12));
            reg_write(ppsa_pkg::REG_SEED, $urandom_range(0, 16'hFFFF));
            send_burst(20);
            drain();
        end

        $display("covered %0d updates, %0d particle transfers checked, registers at extremes",
                 updates_sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("PASS particle_pool_spawn_and_age");
        end else begin
            $display("%0d mismatches, %0d particles missing", sb.mismatches,
                     sb.pending.size());
            $display("FAIL particle_pool_spawn_and_age");
        end
        $finish;
    end
endmodule
